### design/assert_macros.svh
// Assertion helpers. Each use checks a property on the rising edge of clk,
// masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/mcas_pkg.sv
`default_nettype none

package mcas_pkg;

  // Width of the person count register and of counters that can hold the count.
  localparam int unsigned N_W        = 4;
  // Fixed widths of the word fields.
  localparam int unsigned IN_COST_W  = 16;
  localparam int unsigned OUT_IDX_W  = 3;
  localparam int unsigned OUT_COST_W = 19;
  // Person count after reset.
  localparam logic [N_W-1:0] PERSONS_RESET = 4'd4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_RUN   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_RUN,
    TS_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    SR_IDLE,
    SR_STEP,
    SR_SWAP,
    SR_UP,
    SR_EVAL,
    SR_DRAIN,
    SR_CMP,
    SR_DONE
  } srch_state_t;

  // Request from the front end to the search engine.
  typedef struct packed {
    logic           start;
    logic [N_W-1:0] n;
  } srch_req_t;

endpackage

`default_nettype wire

### design/mcas_cost_mem.sv
`default_nettype none

// Cost matrix store: one write port, one read port, registered read data.
module mcas_cost_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/mcas_search.sv
`default_nettype none
`include "assert_macros.svh"

// Permutation walker and cost evaluator. The permutation and the per-level
// swap positions sit in small register files, each read at one place a cycle.
module mcas_search import mcas_pkg::*; #(
  parameter int unsigned MAX_PERSONS = 8,
  parameter int unsigned COST_BITS   = 16,
  localparam int unsigned PW    = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1,
  localparam int unsigned DEPTH = MAX_PERSONS * MAX_PERSONS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned SUM_W = COST_BITS + 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire srch_req_t            req,
  output logic      [AW-1:0]        raddr,
  input  wire logic [COST_BITS-1:0] rdata,
  output logic                      done,
  output logic      [PW-1:0]        best_perm_o [MAX_PERSONS],
  output logic      [SUM_W-1:0]     best_cost_o
);

  srch_state_t      st_r, st_nxt;
  logic [PW-1:0]    perm_r [MAX_PERSONS];
  logic [PW-1:0]    perm_nxt [MAX_PERSONS];
  logic [N_W-1:0]   lp_r [MAX_PERSONS];
  logic [N_W-1:0]   lp_nxt [MAX_PERSONS];
  logic [PW-1:0]    best_perm_r [MAX_PERSONS];
  logic [PW-1:0]    best_perm_nxt [MAX_PERSONS];
  logic [PW-1:0]    level_r, level_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [PW-1:0]    tmp_r, tmp_nxt;
  logic [PW-1:0]    swap_a_r, swap_a_nxt;
  logic [PW-1:0]    swap_b_r, swap_b_nxt;
  logic [PW-1:0]    p_r, p_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  logic [PW-1:0]    lp_idx;
  logic [N_W-1:0]   lp_rd;
  logic [PW-1:0]    perm_idx;
  logic [PW-1:0]    perm_rd;

  // One read of each register file per cycle.
  assign lp_idx = (st_r == SR_UP) ? level_r - PW'(1) : level_r;
  assign lp_rd  = lp_r[lp_idx];

  always_comb begin
    unique case (st_r)
      SR_STEP, SR_UP: perm_idx = PW'(lp_rd);
      SR_SWAP:        perm_idx = swap_b_r;
      default:        perm_idx = p_r;
    endcase
  end

  assign perm_rd = perm_r[perm_idx];
  assign raddr   = AW'(p_r) * AW'(MAX_PERSONS) + AW'(perm_rd);

  always_comb begin
    st_nxt        = st_r;
    perm_nxt      = perm_r;
    lp_nxt        = lp_r;
    best_perm_nxt = best_perm_r;
    level_nxt     = level_r;
    n_nxt         = n_r;
    tmp_nxt       = tmp_r;
    swap_a_nxt    = swap_a_r;
    swap_b_nxt    = swap_b_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    best_vld_nxt  = best_vld_r;
    rd_vld_nxt    = 1'b0;

    unique case (st_r)
      SR_IDLE: begin
        if (req.start) begin
          for (int i = 0; i < MAX_PERSONS; i++) begin
            perm_nxt[i] = PW'(i);
          end
          lp_nxt[0]    = '0;
          level_nxt    = '0;
          n_nxt        = req.n;
          best_vld_nxt = 1'b0;
          st_nxt       = SR_STEP;
        end
      end
      SR_STEP: begin
        if (N_W'(level_r) == n_r - N_W'(1)) begin
          // Full permutation reached: sum its costs.
          acc_nxt = '0;
          p_nxt   = '0;
          st_nxt  = SR_EVAL;
        end else if (lp_rd >= n_r) begin
          st_nxt = SR_UP;
        end else begin
          // Descend: swap position lp[k] into k, open level k+1.
          tmp_nxt                = perm_rd;
          swap_a_nxt             = PW'(lp_rd);
          swap_b_nxt             = level_r;
          level_nxt              = level_r + PW'(1);
          lp_nxt[level_r + PW'(1)] = N_W'(level_r) + N_W'(1);
          st_nxt                 = SR_SWAP;
        end
      end
      SR_SWAP: begin
        perm_nxt[swap_a_r] = perm_rd;
        perm_nxt[swap_b_r] = tmp_r;
        st_nxt             = SR_STEP;
      end
      SR_UP: begin
        if (level_r == '0) begin
          st_nxt = SR_DONE;
        end else begin
          // Return: undo the swap of the level above and advance its position.
          tmp_nxt        = perm_rd;
          swap_a_nxt     = PW'(lp_rd);
          swap_b_nxt     = lp_idx;
          level_nxt      = lp_idx;
          lp_nxt[lp_idx] = lp_rd + N_W'(1);
          st_nxt         = SR_SWAP;
        end
      end
      SR_EVAL: begin
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          acc_nxt = acc_r + SUM_W'(rdata);
        end
        if (N_W'(p_r) == n_r - N_W'(1)) begin
          st_nxt = SR_DRAIN;
        end else begin
          p_nxt = p_r + PW'(1);
        end
      end
      SR_DRAIN: begin
        acc_nxt = acc_r + SUM_W'(rdata);
        st_nxt  = SR_CMP;
      end
      SR_CMP: begin
        // Less or equal, so a tie goes to the later permutation.
        if (!best_vld_r || acc_r <= best_r) begin
          best_nxt      = acc_r;
          best_vld_nxt  = 1'b1;
          best_perm_nxt = perm_r;
        end
        st_nxt = SR_UP;
      end
      SR_DONE: begin
        st_nxt = SR_IDLE;
      end
      default: begin
        st_nxt = SR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= SR_IDLE;
      best_vld_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      best_vld_r <= best_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    perm_r      <= perm_nxt;
    lp_r        <= lp_nxt;
    best_perm_r <= best_perm_nxt;
    level_r     <= level_nxt;
    n_r         <= n_nxt;
    tmp_r       <= tmp_nxt;
    swap_a_r    <= swap_a_nxt;
    swap_b_r    <= swap_b_nxt;
    p_r         <= p_nxt;
    acc_r       <= acc_nxt;
    best_r      <= best_nxt;
  end

  assign done        = (st_r == SR_DONE);
  assign best_perm_o = best_perm_r;
  assign best_cost_o = best_r;

  `ASSERT_HOLDS(a_level_in_range, st_r != SR_IDLE, N_W'(level_r) < n_r)
  `ASSERT_HOLDS(a_eval_row_in_range, st_r == SR_EVAL, N_W'(p_r) < n_r)
  `ASSERT_HOLDS(a_swap_order, st_r == SR_SWAP, swap_a_r >= swap_b_r && N_W'(swap_a_r) < n_r)

endmodule

`default_nettype wire

### design/min_cost_assignment_search.sv
// Cost write words are taken one per cycle while no run is in progress and give
// no result. A run word occupies the block while it walks the search tree and
// sums each leaf through the one read port of the cost memory; n result words
// then follow.
// Reset (rst_n low, synchronous) clears control state and sets the person
// count to four; the cost store is not cleared and must be written before use.
`default_nettype none
`include "assert_macros.svh"

// Exhaustive minimum-cost assignment search. Write words fill the cost matrix
// held in a synchronous memory; a run word walks every permutation of jobs in
// swap order, sums each one by reading one cost entry per cycle, and keeps the
// cheapest (a tie goes to the later permutation). The result words then leave
// through an output register, one per person. Input is held off while a run
// and its output are in progress, so memory writes never meet search reads.
module min_cost_assignment_search import mcas_pkg::*; #(
  parameter int unsigned MAX_PERSONS = 8,
  parameter int unsigned COST_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [OUT_IDX_W-1:0]  in_person,
  input  wire logic [OUT_IDX_W-1:0]  in_job,
  input  wire logic [IN_COST_W-1:0]  in_cost,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [OUT_IDX_W-1:0]  out_person_out,
  output logic      [OUT_IDX_W-1:0]  out_assigned_job,
  output logic      [OUT_COST_W-1:0] out_total_cost,
  output logic                       out_last_of_run,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [N_W-1:0]        cfg_data
);

  localparam int unsigned PW    = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
  localparam int unsigned DEPTH = MAX_PERSONS * MAX_PERSONS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W = COST_BITS + 4;

  top_state_t            state_r, state_nxt;
  logic [N_W-1:0]        persons_r;
  logic [N_W-1:0]        n_act;
  logic [N_W-1:0]        n_r, n_nxt;
  logic [N_W-1:0]        emit_r, emit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]  out_person_r, out_person_nxt;
  logic [OUT_IDX_W-1:0]  out_job_r, out_job_nxt;
  logic [OUT_COST_W-1:0] out_cost_r, out_cost_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_fire;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COST_BITS-1:0]  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [COST_BITS-1:0]  mem_rdata;
  srch_req_t             srch_req;
  logic                  srch_done;
  logic [PW-1:0]         best_perm [MAX_PERSONS];
  logic [SUM_W-1:0]      best_cost;

  // The person count register takes a write whenever one is offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persons_r <= PERSONS_RESET;
    end else if (cfg_valid) begin
      persons_r <= cfg_data;
    end
  end

  // Zero counts as one person, anything above the matrix size as the full size.
  always_comb begin
    if (persons_r == '0) begin
      n_act = N_W'(1);
    end else if (persons_r > N_W'(MAX_PERSONS)) begin
      n_act = N_W'(MAX_PERSONS);
    end else begin
      n_act = persons_r;
    end
  end

  assign in_ready = (state_r == TS_IDLE);
  assign in_fire  = in_valid && in_ready;

  // A write outside the matrix is dropped.
  assign mem_we    = in_fire && (in_command == CMD_WRITE) &&
                     (N_W'(in_person) < N_W'(MAX_PERSONS)) &&
                     (N_W'(in_job) < N_W'(MAX_PERSONS));
  assign mem_waddr = AW'(in_person) * AW'(MAX_PERSONS) + AW'(in_job);
  assign mem_wdata = COST_BITS'(in_cost);

  assign srch_req.start = in_fire && (in_command == CMD_RUN);
  assign srch_req.n     = n_act;

  mcas_cost_mem #(
    .DEPTH (DEPTH),
    .WIDTH (COST_BITS)
  ) u_cost_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mcas_search #(
    .MAX_PERSONS (MAX_PERSONS),
    .COST_BITS   (COST_BITS)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (srch_req),
    .raddr       (mem_raddr),
    .rdata       (mem_rdata),
    .done        (srch_done),
    .best_perm_o (best_perm),
    .best_cost_o (best_cost)
  );

  // Front-end sequencer and the output register. A new word is loaded when
  // the register is empty or its word is taken in the same cycle.
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_person_nxt = out_person_r;
    out_job_nxt    = out_job_r;
    out_cost_nxt   = out_cost_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      TS_IDLE: begin
        if (srch_req.start) begin
          n_nxt     = n_act;
          state_nxt = TS_RUN;
        end
      end
      TS_RUN: begin
        if (srch_done) begin
          emit_nxt  = '0;
          state_nxt = TS_EMIT;
        end
      end
      TS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_person_nxt = OUT_IDX_W'(emit_r);
          out_job_nxt    = OUT_IDX_W'(best_perm[PW'(emit_r)]);
          out_cost_nxt   = OUT_COST_W'(best_cost);
          out_last_nxt   = (emit_r == n_r - N_W'(1));
          if (emit_r == n_r - N_W'(1)) begin
            emit_nxt  = '0;
            state_nxt = TS_IDLE;
          end else begin
            emit_nxt = emit_r + N_W'(1);
          end
        end
      end
      default: begin
        state_nxt = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_IDLE;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    out_person_r <= out_person_nxt;
    out_job_r    <= out_job_nxt;
    out_cost_r   <= out_cost_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_person_out   = out_person_r;
  assign out_assigned_job = out_job_r;
  assign out_total_cost   = out_cost_r;
  assign out_last_of_run  = out_last_r;

  `ASSERT_HOLDS(a_done_in_run, srch_done, state_r == TS_RUN)
  `ASSERT_HOLDS(a_idle_emit_clear, state_r == TS_IDLE, emit_r == '0)
  `ASSERT_HOLDS(a_no_write_busy, mem_we, state_r == TS_IDLE)

endmodule

`default_nettype wire

### tb/mcas_result_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the assignment search block, keeps its own
// copy of the cost matrix and the person count, and checks every result word.
module mcas_result_checker import mcas_pkg::*; #(
  parameter int unsigned MAX_PERSONS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  in_command,
  input  wire logic [OUT_IDX_W-1:0]  in_person,
  input  wire logic [OUT_IDX_W-1:0]  in_job,
  input  wire logic [IN_COST_W-1:0]  in_cost,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [OUT_IDX_W-1:0]  out_person_out,
  input  wire logic [OUT_IDX_W-1:0]  out_assigned_job,
  input  wire logic [OUT_COST_W-1:0] out_total_cost,
  input  wire logic                  out_last_of_run,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [N_W-1:0]        cfg_data,
  output int unsigned                mismatches,
  output int unsigned                outstanding,
  output int unsigned                words_checked
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0]  person;
    logic [OUT_IDX_W-1:0]  job;
    logic [OUT_COST_W-1:0] total;
    logic                  last_flag;
  } assignment_word_t;

  logic [IN_COST_W-1:0] cost_tbl [MAX_PERSONS][MAX_PERSONS];
  logic [N_W-1:0]       persons_reg;
  assignment_word_t     assignment_q [$];
  int unsigned          bad_words;
  int unsigned          good_count;

  function automatic int unsigned clamp_persons(input logic [N_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_PERSONS) return MAX_PERSONS;
    return setting;
  endfunction

  // Walks every job order in swap order, keeps the cheapest one (a tie goes to
  // the later order) and queues one word per person.
  function automatic void search_cheapest(input int unsigned n);
    logic [OUT_IDX_W-1:0] order [MAX_PERSONS];
    logic [OUT_IDX_W-1:0] best_order [MAX_PERSONS];
    int unsigned          pos [MAX_PERSONS + 1];
    int unsigned          lvl;
    int unsigned          p;
    logic [OUT_IDX_W-1:0] tmp;
    logic [31:0]          sum;
    logic [31:0]          best;
    bit                   done;
    assignment_word_t     w;
    for (p = 0; p < MAX_PERSONS; p++) begin
      order[p]      = OUT_IDX_W'(p);
      best_order[p] = '0;
      pos[p]        = 0;
    end
    best = '1;
    lvl  = 0;
    done = 1'b0;
    while (!done) begin
      if (lvl == n - 1 || pos[lvl] >= n) begin
        if (lvl == n - 1) begin
          sum = '0;
          for (p = 0; p < n; p++) sum += cost_tbl[p][order[p]];
          if (sum <= best) begin
            best = sum;
            for (p = 0; p < n; p++) best_order[p] = order[p];
          end
        end
        if (lvl == 0) begin
          done = 1'b1;
        end else begin
          lvl = lvl - 1;
          tmp = order[pos[lvl]];
          order[pos[lvl]] = order[lvl];
          order[lvl] = tmp;
          pos[lvl]++;
        end
      end else begin
        tmp = order[pos[lvl]];
        order[pos[lvl]] = order[lvl];
        order[lvl] = tmp;
        lvl = lvl + 1;
        pos[lvl] = lvl;
      end
    end
    for (p = 0; p < n; p++) begin
      w.person    = OUT_IDX_W'(p);
      w.job       = best_order[p];
      w.total     = best[OUT_COST_W-1:0];
      w.last_flag = (p == n - 1);
      assignment_q.push_back(w);
    end
  endfunction

  task automatic compare_word();
    assignment_word_t want;
    if (assignment_q.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("%0t: result word with nothing expected: person %0d job %0d %s %0d %0b",
                 $realtime, out_person_out, out_assigned_job, "total, last",
                 out_total_cost, out_last_of_run);
    end else begin
      want = assignment_q.pop_front();
      if (want.person !== out_person_out || want.job !== out_assigned_job ||
          want.total !== out_total_cost || want.last_flag !== out_last_of_run) begin
        bad_words++;
        if (bad_words <= 10)
          $display({"%0t: mismatch, expected person %0d job %0d total %0d last %0b,",
                    " got %0d %0d %0d %0b"},
                   $realtime, want.person, want.job, want.total, want.last_flag,
                   out_person_out, out_assigned_job, out_total_cost, out_last_of_run);
      end else begin
        good_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      persons_reg = PERSONS_RESET;
      assignment_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) persons_reg = cfg_data;
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE) begin
          if (in_person < MAX_PERSONS && in_job < MAX_PERSONS)
            cost_tbl[in_person][in_job] = in_cost;
        end else begin
          search_cheapest(clamp_persons(persons_reg));
        end
      end
      if (out_valid && out_ready) compare_word();
    end
    outstanding   <= assignment_q.size();
    mismatches    <= bad_words;
    words_checked <= good_count + bad_words;
  end

endmodule

### tb/min_cost_assignment_search_tb.sv
`timescale 1ns / 1ps

// Top of the regression for the exhaustive assignment search. This module only
// makes stimulus and gives the verdict; the checker beside the block predicts
// and compares every result word.
module min_cost_assignment_search_tb;
  import mcas_pkg::*;

  // Cycles to let pass after the last expected word before touching the
  // person count, so that trailing cost writes have landed in the memory.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Cycles to watch for stray words once everything expected has come.
  localparam int unsigned TAIL_CYCLES   = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_command = CMD_WRITE;
  logic [OUT_IDX_W-1:0]  in_person = '0;
  logic [OUT_IDX_W-1:0]  in_job    = '0;
  logic [IN_COST_W-1:0]  in_cost   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_IDX_W-1:0]  out_person_out;
  logic [OUT_IDX_W-1:0]  out_assigned_job;
  logic [OUT_COST_W-1:0] out_total_cost;
  logic                  out_last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [N_W-1:0]        cfg_data  = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_checked;

  // Idle rates in percent; they change as the run goes on.
  int unsigned send_gap_pct   = 21;
  int unsigned recv_stall_pct = 54;

  // Stimulus bookkeeping: which cost entries hold a known value, and the
  // person count that the block is working with right now.
  bit [63:0]   cost_written = '0;
  int unsigned active_n     = 4;
  int unsigned words_sent   = 0;
  int unsigned searches     = 0;
  int unsigned cost_writes  = 0;

  always #6 clk = ~clk;

  min_cost_assignment_search uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_person       (in_person),
    .in_job          (in_job),
    .in_cost         (in_cost),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_person_out  (out_person_out),
    .out_assigned_job(out_assigned_job),
    .out_total_cost  (out_total_cost),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  mcas_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_person       (in_person),
    .in_job          (in_job),
    .in_cost         (in_cost),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_person_out  (out_person_out),
    .out_assigned_job(out_assigned_job),
    .out_total_cost  (out_total_cost),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .words_checked   (words_checked)
  );

  // The receiver drops ready at random; the rate follows the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // A run with n = 8 walks 40320 orders and dominates the run time; this
  // bound leaves several times the slowest expected run.
  initial begin
    #100_000_000;
    $display("min_cost_assignment_search regression: fail");
    $finish;
  end

  // Costs lean toward small values so that ties are common, with the two
  // extremes showing up often as well.
  function automatic logic [IN_COST_W-1:0] pick_cost();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return IN_COST_W'($urandom_range(7));
      default: return IN_COST_W'($urandom);
    endcase
  endfunction

  // Presents one word and holds it until the block takes it. Valid is left
  // high on return so that back-to-back words never lower and raise it in
  // the same time step; it only drops when a gap or a pause is wanted.
  task automatic send_word(input cmd_t cmd, input logic [OUT_IDX_W-1:0] who,
                           input logic [OUT_IDX_W-1:0] what,
                           input logic [IN_COST_W-1:0] amount);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_person  <= who;
    in_job     <= what;
    in_cost    <= amount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    // First the sender idles lightly and the receiver heavily, then the
    // other way round, and the last stretch runs with no idling at all.
    if (words_sent == 160) begin
      send_gap_pct   = 54;
      recv_stall_pct = 21;
    end else if (words_sent == 320) begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic write_cost(input logic [OUT_IDX_W-1:0] who,
                            input logic [OUT_IDX_W-1:0] what,
                            input logic [IN_COST_W-1:0] amount);
    send_word(CMD_WRITE, who, what, amount);
    cost_written[who * 8 + what] = 1'b1;
    cost_writes++;
  endtask

  // The block must never read an entry that was not written, so any hole in
  // the active corner of the matrix is filled before the run word goes out.
  // The index and cost fields of a run word are ignored by the block.
  task automatic start_search(input logic [OUT_IDX_W-1:0] who,
                              input logic [OUT_IDX_W-1:0] what,
                              input logic [IN_COST_W-1:0] amount);
    int unsigned p;
    int unsigned j;
    for (p = 0; p < active_n; p++)
      for (j = 0; j < active_n; j++)
        if (!cost_written[p * 8 + j])
          write_cost(OUT_IDX_W'(p), OUT_IDX_W'(j), pick_cost());
    send_word(CMD_RUN, who, what, amount);
    searches++;
  endtask

  // Holds the input off until every expected result word has come back.
  // The first edge lets the checker's count catch up with the last word.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // The person count is only changed while the block is idle.
  task automatic set_persons(input logic [N_W-1:0] setting);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    active_n = (setting == 0) ? 1 : (setting > 8) ? 8 : setting;
  endtask

  // One phase at a fixed person count: mostly cost writes inside the active
  // corner, some anywhere in the matrix, runs at the given rate, and always a
  // closing run so that the last writes are seen in a result.
  task automatic random_phase(input logic [N_W-1:0] setting, input int unsigned words,
                              input int unsigned run_pct);
    int unsigned i;
    set_persons(setting);
    for (i = 0; i < words; i++) begin
      if ($urandom_range(99) < run_pct) begin
        start_search(OUT_IDX_W'($urandom), OUT_IDX_W'($urandom), IN_COST_W'($urandom));
        // Now and then the sender waits out the whole result burst.
        if ($urandom_range(99) < 10) drain_results();
      end else if ($urandom_range(9) < 7) begin
        write_cost(OUT_IDX_W'($urandom_range(active_n - 1)),
                   OUT_IDX_W'($urandom_range(active_n - 1)), pick_cost());
      end else begin
        write_cost(OUT_IDX_W'($urandom_range(7)), OUT_IDX_W'($urandom_range(7)),
                   pick_cost());
      end
    end
    start_search(OUT_IDX_W'($urandom), OUT_IDX_W'($urandom), IN_COST_W'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A count of zero must act as one person, with the
    // largest cost and all index bits set on the ignored fields of the run.
    set_persons(4'd0);
    write_cost(3'd0, 3'd0, 16'hFFFF);
    start_search(3'd7, 3'd7, 16'hFFFF);

    // Two persons, every cost zero: both orders tie and the later one wins.
    set_persons(4'd2);
    write_cost(3'd0, 3'd0, 16'd0);
    write_cost(3'd0, 3'd1, 16'd0);
    write_cost(3'd1, 3'd0, 16'd0);
    write_cost(3'd1, 3'd1, 16'd0);
    start_search(3'd0, 3'd0, 16'd0);

    // Every cost at its maximum: again a tie, now with the largest sum.
    write_cost(3'd0, 3'd0, 16'hFFFF);
    write_cost(3'd0, 3'd1, 16'hFFFF);
    write_cost(3'd1, 3'd0, 16'hFFFF);
    write_cost(3'd1, 3'd1, 16'hFFFF);
    start_search(3'd5, 3'd2, 16'hA5A5);

    // Writes at the far corner of the matrix must not disturb a small run.
    write_cost(3'd7, 3'd7, 16'h0000);
    write_cost(3'd7, 3'd0, 16'h0001);
    write_cost(3'd0, 3'd7, 16'h8000);
    start_search(3'd3, 3'd4, 16'h5A5A);

    // Random part, mostly at small person counts where a run is cheap. The
    // seven and eight person phases each end in a single long run; a count
    // above the maximum is clamped to eight.
    random_phase(4'd3, 70, 25);
    random_phase(4'd1, 30, 30);
    random_phase(4'd4, 70, 20);
    random_phase(4'd5, 50, 15);
    random_phase(4'd6, 25, 6);
    random_phase(4'd7, 25, 0);
    random_phase(4'd15, 25, 0);
    random_phase(4'd2, 60, 30);
    random_phase(4'd0, 15, 30);
    random_phase(4'd4, 30, 20);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d searches over one to eight persons with %0d cost writes;",
             searches, cost_writes);
    $display("%0d result words checked, %0d found wrong.", words_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("min_cost_assignment_search regression: pass");
    end else begin
      $display("min_cost_assignment_search regression: fail");
    end
    $finish;
  end

endmodule
